// File: rtl/core/tan_pkg.sv
`default_nettype none

package tan_pkg;

  // request kinds carried in the input tuser
  typedef enum logic [1:0] {
    CMD_NEXT_HOP = 2'd0,
    CMD_ROUTER   = 2'd1,
    CMD_END_DEV  = 2'd2,
    CMD_UNUSED   = 2'd3
  } tan_cmd_e;

  // configuration register indexes
  localparam logic [2:0] REG_CHILD_CAP   = 3'd0;
  localparam logic [2:0] REG_ROUTER_CAP  = 3'd1;
  localparam logic [2:0] REG_DEPTH_CAP   = 3'd2;
  localparam logic [2:0] REG_OWN_DEPTH   = 3'd3;
  localparam logic [2:0] REG_OWN_ADDR    = 3'd4;
  localparam logic [2:0] REG_PARENT_ADDR = 3'd5;

  localparam logic [15:0] ADDR_INVALID = 16'hFFFF;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CSK_PAR,
    OP_CSK_OWN,
    OP_CSK_ITER,
    OP_CSK_FIN,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_RES_SCAN,
    OP_MUL_RTR,
    OP_MUL_END,
    OP_RES_PROD,
    OP_RES_BAD,
    OP_RES_PARENT,
    OP_RES_DEST,
    OP_EMIT
  } tan_op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_CMD_RTR,
    C_CMD_END,
    C_CMD_BAD,
    C_CNT_NZ,
    C_UP,
    C_NBR,
    C_SCAN_GO,
    C_OUT_BUSY
  } tan_cond_e;

  typedef logic [4:0] tan_pc_t;

  typedef struct packed {
    tan_op_e   op;
    tan_cond_e cond;
    tan_pc_t   target;
  } tan_cw_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic cmd_rtr;
    logic cmd_end;
    logic cmd_bad;
    logic cnt_nz;
    logic up;
    logic nbr;
    logic scan_go;
    logic out_busy;
  } tan_flags_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [7:0]  child_cap;
    logic [7:0]  router_cap;
    logic [3:0]  depth_cap;
    logic [3:0]  own_depth;
    logic [15:0] own_addr;
    logic [15:0] parent_addr;
  } tan_cfg_t;

  // program addresses
  localparam tan_pc_t ST_IDLE       = 5'd0;
  localparam tan_pc_t ST_DISP_RTR   = 5'd1;
  localparam tan_pc_t ST_DISP_END   = 5'd2;
  localparam tan_pc_t ST_DISP_BAD   = 5'd3;
  localparam tan_pc_t ST_PAR_INIT   = 5'd4;
  localparam tan_pc_t ST_PAR_LOOP   = 5'd5;
  localparam tan_pc_t ST_PAR_FIN    = 5'd6;
  localparam tan_pc_t ST_UP         = 5'd7;
  localparam tan_pc_t ST_NBR        = 5'd8;
  localparam tan_pc_t ST_OWN_INIT   = 5'd9;
  localparam tan_pc_t ST_OWN_LOOP   = 5'd10;
  localparam tan_pc_t ST_OWN_FIN    = 5'd11;
  localparam tan_pc_t ST_SCAN_INIT  = 5'd12;
  localparam tan_pc_t ST_SCAN       = 5'd13;
  localparam tan_pc_t ST_SCAN_RES   = 5'd14;
  localparam tan_pc_t ST_MUL_RTR    = 5'd15;
  localparam tan_pc_t ST_RES_PROD   = 5'd16;
  localparam tan_pc_t ST_MUL_END    = 5'd17;
  localparam tan_pc_t ST_RES_BAD    = 5'd18;
  localparam tan_pc_t ST_RES_PARENT = 5'd19;
  localparam tan_pc_t ST_RES_DEST   = 5'd20;
  localparam tan_pc_t ST_EMIT       = 5'd21;
  localparam tan_pc_t ST_RETURN     = 5'd22;

  function automatic tan_cw_t cw(tan_op_e op, tan_cond_e cond, tan_pc_t target);
    tan_cw_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // microcode rom: next pc is target when the condition holds, else pc + 1
  function automatic tan_cw_t tan_ucode(tan_pc_t pc);
    tan_cw_t w;
    unique case (pc)
      ST_IDLE:       w = cw(OP_LOAD,       C_NO_IN,    ST_IDLE);
      ST_DISP_RTR:   w = cw(OP_NONE,       C_CMD_RTR,  ST_MUL_RTR);
      ST_DISP_END:   w = cw(OP_NONE,       C_CMD_END,  ST_MUL_END);
      ST_DISP_BAD:   w = cw(OP_NONE,       C_CMD_BAD,  ST_RES_BAD);
      ST_PAR_INIT:   w = cw(OP_CSK_PAR,    C_NEVER,    ST_IDLE);
      ST_PAR_LOOP:   w = cw(OP_CSK_ITER,   C_CNT_NZ,   ST_PAR_LOOP);
      ST_PAR_FIN:    w = cw(OP_CSK_FIN,    C_NEVER,    ST_IDLE);
      ST_UP:         w = cw(OP_NONE,       C_UP,       ST_RES_PARENT);
      ST_NBR:        w = cw(OP_NONE,       C_NBR,      ST_RES_DEST);
      ST_OWN_INIT:   w = cw(OP_CSK_OWN,    C_NEVER,    ST_IDLE);
      ST_OWN_LOOP:   w = cw(OP_CSK_ITER,   C_CNT_NZ,   ST_OWN_LOOP);
      ST_OWN_FIN:    w = cw(OP_CSK_FIN,    C_NEVER,    ST_IDLE);
      ST_SCAN_INIT:  w = cw(OP_SCAN_INIT,  C_NEVER,    ST_IDLE);
      ST_SCAN:       w = cw(OP_SCAN,       C_SCAN_GO,  ST_SCAN);
      ST_SCAN_RES:   w = cw(OP_RES_SCAN,   C_ALWAYS,   ST_EMIT);
      ST_MUL_RTR:    w = cw(OP_MUL_RTR,    C_NEVER,    ST_IDLE);
      ST_RES_PROD:   w = cw(OP_RES_PROD,   C_ALWAYS,   ST_EMIT);
      ST_MUL_END:    w = cw(OP_MUL_END,    C_ALWAYS,   ST_RES_PROD);
      ST_RES_BAD:    w = cw(OP_RES_BAD,    C_ALWAYS,   ST_EMIT);
      ST_RES_PARENT: w = cw(OP_RES_PARENT, C_ALWAYS,   ST_EMIT);
      ST_RES_DEST:   w = cw(OP_RES_DEST,   C_NEVER,    ST_IDLE);
      ST_EMIT:       w = cw(OP_EMIT,       C_OUT_BUSY, ST_EMIT);
      ST_RETURN:     w = cw(OP_NONE,       C_ALWAYS,   ST_IDLE);
      default:       w = cw(OP_NONE,       C_ALWAYS,   ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tan_sequencer.sv
`default_nettype none

module tan_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  tan_pkg::tan_flags_t flags_i,
  output tan_pkg::tan_op_e   op_o,
  output logic               idle_o
);
  import tan_pkg::*;

  tan_pc_t pc_q, pc_d;
  tan_cw_t cw_w;
  logic    take;

  // fetch the control word for the current step
  assign cw_w   = tan_ucode(pc_q);
  assign op_o   = cw_w.op;
  assign idle_o = (pc_q == ST_IDLE);

  // condition select
  always_comb begin
    unique case (cw_w.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !flags_i.in_valid;
      C_CMD_RTR:  take = flags_i.cmd_rtr;
      C_CMD_END:  take = flags_i.cmd_end;
      C_CMD_BAD:  take = flags_i.cmd_bad;
      C_CNT_NZ:   take = flags_i.cnt_nz;
      C_UP:       take = flags_i.up;
      C_NBR:      take = flags_i.nbr;
      C_SCAN_GO:  take = flags_i.scan_go;
      C_OUT_BUSY: take = flags_i.out_busy;
      default:    take = 1'b0;
    endcase
  end

  // step counter with conditional jump
  assign pc_d = take ? cw_w.target : tan_pc_t'(pc_q + 5'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tan_datapath.sv
`default_nettype none

module tan_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  tan_pkg::tan_cfg_t   cfg_i,
  input  tan_pkg::tan_op_e    op_i,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_cmd_i,
  input  wire logic [15:0]    in_dest_i,
  input  wire logic           in_nbr_i,
  input  wire logic [7:0]     in_num_i,
  input  wire logic [15:0]    in_cskip_i,
  output tan_pkg::tan_flags_t flags_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [15:0]         out_addr_o,
  output logic                out_ok_o
);
  import tan_pkg::*;

  // latched item
  logic [1:0]  cmd_q;
  logic [15:0] dest_q;
  logic        nbr_q;
  logic [7:0]  num_q;
  logic [15:0] csk_q;

  // cskip engine and scan
  logic [15:0] sum_q, pw_q, cs_q, lo_q, prod_q;
  logic [3:0]  cnt_q;
  logic        zero_q;
  logic [7:0]  idx_q;

  // result and output register
  logic [15:0] res_addr_q, out_addr_q;
  logic        res_ok_q, out_ok_q, out_valid_q;

  logic        load;
  logic [3:0]  dpar;
  logic        zero_par, zero_own;
  logic [3:0]  e_par, e_own;
  logic [23:0] pw_mul, cs_mul, rtr_mul, end_mul;
  logic [15:0] hi_w;
  logic        hit, scan_go, down, out_busy;
  logic [16:0] down_lim;

  assign load = (op_i == OP_LOAD) && in_valid_i;

  // exponent set-up for parent depth and own depth
  assign dpar     = cfg_i.own_depth - 4'd1;
  assign zero_par = (cfg_i.own_depth == 4'd0) || (dpar >= cfg_i.depth_cap);
  assign zero_own = (cfg_i.own_depth >= cfg_i.depth_cap);
  assign e_par    = cfg_i.depth_cap - dpar - 4'd1;
  assign e_own    = cfg_i.depth_cap - cfg_i.own_depth - 4'd1;

  // one multiplier each, registered
  assign pw_mul  = pw_q * cfg_i.router_cap;
  assign cs_mul  = sum_q * cfg_i.child_cap;
  assign rtr_mul = csk_q * num_q;
  assign end_mul = csk_q * cfg_i.router_cap;

  // downward range and child block scan
  assign down_lim = {1'b0, cfg_i.own_addr} + {1'b0, cs_q};
  assign down     = (dest_q > cfg_i.own_addr) && ({1'b0, dest_q} < down_lim);
  assign hi_w     = lo_q + cs_q;
  assign hit      = (dest_q > lo_q) && (dest_q < hi_w);
  assign scan_go  = (idx_q != cfg_i.router_cap) && !hit;
  assign out_busy = out_valid_q && !out_ready_i;

  // flags for the sequencer
  always_comb begin
    flags_o.in_valid = in_valid_i;
    flags_o.cmd_rtr  = (cmd_q == CMD_ROUTER);
    flags_o.cmd_end  = (cmd_q == CMD_END_DEV);
    flags_o.cmd_bad  = (cmd_q == CMD_UNUSED);
    flags_o.cnt_nz   = (cnt_q != 4'd0);
    flags_o.up       = (cfg_i.own_addr != 16'd0) && !down;
    flags_o.nbr      = nbr_q;
    flags_o.scan_go  = scan_go;
    flags_o.out_busy = out_busy;
  end

  // payload registers driven by the current operation
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= in_cmd_i;
      dest_q <= in_dest_i;
      nbr_q  <= in_nbr_i;
      num_q  <= in_num_i;
      csk_q  <= in_cskip_i;
    end
    case (op_i)
      OP_CSK_PAR: begin
        sum_q  <= 16'd0;
        pw_q   <= 16'd1;
        zero_q <= zero_par;
        cnt_q  <= zero_par ? 4'd0 : e_par;
      end
      OP_CSK_OWN: begin
        sum_q  <= 16'd0;
        pw_q   <= 16'd1;
        zero_q <= zero_own;
        cnt_q  <= zero_own ? 4'd0 : e_own;
      end
      OP_CSK_ITER: begin
        if (cnt_q != 4'd0) begin
          sum_q <= sum_q + pw_q;
          pw_q  <= pw_mul[15:0];
          cnt_q <= cnt_q - 4'd1;
        end
      end
      OP_CSK_FIN: begin
        cs_q <= zero_q ? 16'd0 : cs_mul[15:0] + 16'd1;
      end
      OP_SCAN_INIT: begin
        lo_q  <= cfg_i.own_addr + 16'd1;
        idx_q <= 8'd0;
      end
      OP_SCAN: begin
        if (scan_go) begin
          lo_q  <= hi_w;
          idx_q <= idx_q + 8'd1;
        end
      end
      OP_RES_SCAN: begin
        res_ok_q   <= hit && (idx_q != cfg_i.router_cap);
        res_addr_q <= (hit && (idx_q != cfg_i.router_cap)) ? lo_q : ADDR_INVALID;
      end
      OP_MUL_RTR: prod_q <= rtr_mul[15:0];
      OP_MUL_END: prod_q <= end_mul[15:0];
      OP_RES_PROD: begin
        res_ok_q   <= 1'b1;
        res_addr_q <= cfg_i.own_addr + prod_q + 16'd1
                      + ((cmd_q == CMD_END_DEV) ? {8'd0, num_q} : 16'd0);
      end
      OP_RES_BAD: begin
        res_ok_q   <= 1'b0;
        res_addr_q <= ADDR_INVALID;
      end
      OP_RES_PARENT: begin
        res_ok_q   <= 1'b1;
        res_addr_q <= cfg_i.parent_addr;
      end
      OP_RES_DEST: begin
        res_ok_q   <= 1'b1;
        res_addr_q <= dest_q;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_addr_q <= res_addr_q;
          out_ok_q   <= res_ok_q;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((op_i == OP_EMIT) && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_ok_o    = out_ok_q;

endmodule

`default_nettype wire

// File: rtl/core/tree_address_next_hop_unit.sv
`default_nettype none

// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: dest, nbr, num, cskip
//           |           |                               | tuser: cmd
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: result_addr
//           |           |                               | tuser: result_valid
// cfg       | in        | cfg_we_i (no wait)            | cfg_idx_i, cfg_data_i
//
// one item at a time, s_axis_tready high only in the idle step; a router child or an end-device
// child goes from dispatch to its multiply step, a next hop first runs the parent cskip loop to
// choose up or neighbour, and a child scan then runs the own cskip loop and steps past up to Rm
// child blocks; after the emit step the sequencer returns to the idle step through its return step.
// reset returns the configuration to its default values and empties the output register.
// a stalled result holds in the output register; the sequencer waits in its emit step.

module tree_address_next_hop_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // dest[15:0], nbr[16], num[24:17], cskip[40:25]
  input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // result_addr[15:0]
  output logic [0:0]       m_axis_tuser,   // result_valid[0]
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import tan_pkg::*;

  tan_cfg_t   cfg_q;
  tan_op_e    op;
  tan_flags_t flags;
  logic       idle;
  logic       out_ok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.child_cap   <= 8'd20;
      cfg_q.router_cap  <= 8'd6;
      cfg_q.depth_cap   <= 4'd5;
      cfg_q.own_depth   <= 4'd0;
      cfg_q.own_addr    <= 16'd0;
      cfg_q.parent_addr <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHILD_CAP:   cfg_q.child_cap   <= cfg_data_i[7:0];
        REG_ROUTER_CAP:  cfg_q.router_cap  <= cfg_data_i[7:0];
        REG_DEPTH_CAP:   cfg_q.depth_cap   <= cfg_data_i[3:0];
        REG_OWN_DEPTH:   cfg_q.own_depth   <= cfg_data_i[3:0];
        REG_OWN_ADDR:    cfg_q.own_addr    <= cfg_data_i;
        REG_PARENT_ADDR: cfg_q.parent_addr <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step counter and control rom
  tan_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op),
    .idle_o  (idle)
  );

  // registers and arithmetic
  tan_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_i        (op),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_dest_i   (s_axis_tdata[15:0]),
    .in_nbr_i    (s_axis_tdata[16]),
    .in_num_i    (s_axis_tdata[24:17]),
    .in_cskip_i  (s_axis_tdata[40:25]),
    .flags_o     (flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_addr_o  (m_axis_tdata),
    .out_ok_o    (out_ok)
  );

  assign s_axis_tready   = idle;
  assign m_axis_tuser[0] = out_ok;

endmodule

`default_nettype wire

// File: rtl/core/tan_checker.sv
`default_nettype none

module tan_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);
  import tan_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no route always carries the invalid address
  a_invalid_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == ADDR_INVALID)
    else $error("invalid result with a real address");

  // once an item is taken the block is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while still working");

  // a new result only appears while the block is busy
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item in work");

endmodule

bind tree_address_next_hop_unit tan_port_checker u_tan_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
